[rtl/core/hps_pkg.sv]
// Package for the harmonic potential planner: grid geometry, codes, control types.
`default_nettype none
package hps_pkg;
    localparam int GridRows = 28;
    localparam int GridCols = 36;
    localparam int Cells = GridRows * GridCols;
    localparam int AddrW = $clog2(Cells);
    localparam int CordicSteps = 16;
    localparam int StepW = $clog2(CordicSteps + 1);
    localparam logic signed [17:0] OneQ16 = 18'sd65536;
    localparam logic [47:0] ErrMax = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SOLVE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_THRESH = 2'd0,
        REG_SWEEPS = 2'd1,
        REG_GAIN   = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    // Commands from controller to datapath.
    typedef enum logic [3:0] {
        DP_IDLE   = 4'd0,
        DP_WRITE  = 4'd1,  // host load into store
        DP_RD     = 4'd2,  // issue store read at addr
        DP_LATCH  = 4'd3,  // latch read data into slot
        DP_CALC   = 4'd4,  // compute relaxation product
        DP_UPD    = 4'd5,  // write new value, accumulate error
        DP_CLRERR = 4'd6,
        DP_CINIT  = 4'd7,  // cordic setup
        DP_CSTEP  = 4'd8,
        DP_MULT   = 4'd9   // latch neighbor sum
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [AddrW-1:0] addr;
        logic [2:0]       slot;   // 0 center,1 up,2 down,3 left,4 right
        logic             oob;    // neighbor outside grid reads as one
    } dp_cmd_t;

    typedef struct packed {
        logic        center_fixed;
        logic [47:0] error_sum;
        logic        flat;
    } dp_stat_t;

    // atan(2^-i) in 1/64 degree times 2^16
    function automatic logic [28:0] atan_tab(input logic [4:0] i);
        logic [28:0] v;
        begin
            unique case (i)
                5'd0: v = 29'd188743680;  5'd1: v = 29'd111421900;
                5'd2: v = 29'd58872272;   5'd3: v = 29'd29884485;
                5'd4: v = 29'd15000234;   5'd5: v = 29'd7507429;
                5'd6: v = 29'd3754631;    5'd7: v = 29'd1877430;
                5'd8: v = 29'd938729;     5'd9: v = 29'd469366;
                5'd10: v = 29'd234683;    5'd11: v = 29'd117342;
                5'd12: v = 29'd58671;     5'd13: v = 29'd29335;
                5'd14: v = 29'd14668;     5'd15: v = 29'd7334;
                5'd16: v = 29'd3667;      5'd17: v = 29'd1833;
                5'd18: v = 29'd917;       5'd19: v = 29'd458;
                5'd20: v = 29'd229;       5'd21: v = 29'd115;
                5'd22: v = 29'd57;        5'd23: v = 29'd29;
                default: v = 29'd0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

[rtl/core/hps_datapath.sv]
// Datapath: potential memory, neighbor registers, relaxation arithmetic, CORDIC.
`default_nettype none
module hps_datapath (
    input  wire logic               clk,
    input  wire hps_pkg::dp_cmd_t   cmd,
    input  wire logic signed [17:0] load_value,
    input  wire logic [15:0]        overrelax_gain,
    output hps_pkg::dp_stat_t       stat,
    output logic signed [17:0]      center,
    output logic signed [14:0]      angle
);
    logic signed [17:0] mem [hps_pkg::Cells];
    logic signed [17:0] rd_reg;
    logic signed [17:0] nb_reg [5];
    logic signed [36:0] prod_reg;
    logic signed [20:0] s_reg;
    logic [47:0]        err_reg;
    logic signed [28:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic [4:0]         ci_reg;

    logic signed [20:0] s_sum;
    logic signed [20:0] diff;
    logic signed [38:0] acc;
    logic signed [20:0] sh;
    logic signed [17:0] nv;
    logic signed [18:0] dch;
    logic [47:0]        dsq;
    logic [48:0]        esum;

    always_ff @(posedge clk)
    begin
        if (cmd.op == hps_pkg::DP_WRITE)
            mem[cmd.addr] <= load_value;
        else if (cmd.op == hps_pkg::DP_UPD && !stat.center_fixed)
            mem[cmd.addr] <= nv;
        rd_reg <= mem[cmd.addr];
    end

    always_comb
    begin
        s_sum = 21'(nb_reg[1]) + 21'(nb_reg[2]) + 21'(nb_reg[3]) + 21'(nb_reg[4]);
        diff  = s_reg - (21'(nb_reg[0]) <<< 2);
        acc   = (39'(s_reg) <<< 16) + 39'(prod_reg) + 39'sd131072;
        sh    = 21'(acc >>> 18);
        if (sh > 21'sd131071) nv = 18'sd131071;
        else if (sh < -21'sd131072) nv = -18'sd131072;
        else nv = sh[17:0];
        dch  = 19'(nv) - 19'(nb_reg[0]);
        dsq  = 48'(38'(dch) * 38'(dch));
        esum = 49'(err_reg) + 49'(dsq);
    end

    // CORDIC step
    logic signed [28:0] xs, ys;
    always_comb
    begin
        xs = cx_reg >>> ci_reg;
        ys = cy_reg >>> ci_reg;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            hps_pkg::DP_LATCH:
                nb_reg[cmd.slot] <= cmd.oob ? hps_pkg::OneQ16 : rd_reg;
            hps_pkg::DP_MULT:
                s_reg <= s_sum;
            hps_pkg::DP_CALC:
                prod_reg <= 37'($signed({1'b0, overrelax_gain}) * diff);
            hps_pkg::DP_UPD:
                if (!stat.center_fixed)
                    err_reg <= esum[48] ? hps_pkg::ErrMax : esum[47:0];
            hps_pkg::DP_CLRERR:
                err_reg <= '0;
            hps_pkg::DP_CINIT:
            begin
                ci_reg <= '0;
                if (((29'(nb_reg[3]) - 29'(nb_reg[4])) <<< 8) < 0)
                begin
                    cx_reg <= -((29'(nb_reg[3]) - 29'(nb_reg[4])) <<< 8);
                    cy_reg <= -((29'(nb_reg[1]) - 29'(nb_reg[2])) <<< 8);
                    cz_reg <= (nb_reg[1] >= nb_reg[2]) ? 32'sd754974720
                                                       : -32'sd754974720;
                end
                else
                begin
                    cx_reg <= (29'(nb_reg[3]) - 29'(nb_reg[4])) <<< 8;
                    cy_reg <= (29'(nb_reg[1]) - 29'(nb_reg[2])) <<< 8;
                    cz_reg <= '0;
                end
            end
            hps_pkg::DP_CSTEP:
            begin
                ci_reg <= ci_reg + 5'd1;
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + 32'($signed({1'b0, hps_pkg::atan_tab(ci_reg)}));
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - 32'($signed({1'b0, hps_pkg::atan_tab(ci_reg)}));
                end
            end
            default: ;
        endcase
    end

    logic signed [16:0] zr;
    logic signed [16:0] neg;
    always_comb
    begin
        center = nb_reg[0];
        stat.center_fixed = (nb_reg[0] == '0) || (nb_reg[0] == hps_pkg::OneQ16);
        stat.error_sum = err_reg;
        stat.flat = (nb_reg[1] == nb_reg[2]) && (nb_reg[3] == nb_reg[4]);
        zr  = 17'((33'(cz_reg) + 33'sd32768) >>> 16);
        neg = -zr;
        if (stat.center_fixed || stat.flat) angle = '0;
        else if (neg > 17'sd11520) angle = 15'sd11520;
        else if (neg < -17'sd11520) angle = -15'sd11520;
        else angle = neg[14:0];
    end
endmodule
`default_nettype wire

[rtl/core/hps_ctrl.sv]
// Controller: sequences loads, sweeps over the grid and the read with CORDIC.
`default_nettype none
module hps_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        operation,
    input  wire logic [4:0]        row,
    input  wire logic [5:0]        col,
    input  wire logic [31:0]       error_threshold,
    input  wire logic [15:0]       max_sweeps,
    input  wire hps_pkg::dp_stat_t stat,
    output hps_pkg::dp_cmd_t       cmd,
    output logic                   busy,
    output logic                   done,
    output logic                   kind,
    output logic [15:0]            sweeps_done,
    output logic                   converged
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_MULT  = 7'b0000100,
        S_CALC  = 7'b0001000,
        S_UPD   = 7'b0010000,
        S_CORD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] r_reg, r_next;
    logic [5:0] c_reg, c_next;
    logic [2:0] k_reg, k_next;     // fetch slot index over the 5 slots
    logic       ph_reg, ph_next;
    logic       solve_reg, solve_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [4:0]  st_reg, st_next;
    logic        conv_reg, conv_next;

    logic signed [6:0] nr;
    logic signed [7:0] nc;
    logic              oob;
    always_comb
    begin
        nr = 7'(r_reg);
        nc = 8'(c_reg);
        unique case (k_reg)
            3'd1: nr = 7'(r_reg) - 7'sd1;
            3'd2: nr = 7'(r_reg) + 7'sd1;
            3'd3: nc = 8'(c_reg) - 8'sd1;
            3'd4: nc = 8'(c_reg) + 8'sd1;
            default: ;
        endcase
        oob = nr < 0 || nr >= 7'(hps_pkg::GridRows) || nc < 0
              || nc >= 8'(hps_pkg::GridCols);
    end

    always_comb
    begin
        state_next = state_reg;
        r_next = r_reg; c_next = c_reg; k_next = k_reg; ph_next = ph_reg;
        solve_next = solve_reg; cnt_next = cnt_reg; st_next = st_reg;
        conv_next = conv_reg;
        cmd.op = hps_pkg::DP_IDLE;
        cmd.addr = hps_pkg::AddrW'(32'(r_reg) * hps_pkg::GridCols + 32'(c_reg));
        cmd.slot = k_reg;
        cmd.oob = oob;
        unique case (state_reg)
            S_IDLE:
                // The result strobe cycle still counts as busy.
                if (start && !done)
                begin
                    r_next = row; c_next = col; k_next = '0; ph_next = 1'b0;
                    unique case (hps_pkg::op_t'(operation))
                        hps_pkg::OP_LOAD:
                            if (row < 5'(hps_pkg::GridRows) && col < 6'(hps_pkg::GridCols))
                            begin
                                cmd.op = hps_pkg::DP_WRITE;
                                cmd.addr = hps_pkg::AddrW'(32'(row) * hps_pkg::GridCols
                                                           + 32'(col));
                            end
                        hps_pkg::OP_SOLVE:
                        begin
                            r_next = '0; c_next = '0; cnt_next = '0;
                            solve_next = 1'b1; cmd.op = hps_pkg::DP_CLRERR;
                            state_next = S_FETCH;
                        end
                        hps_pkg::OP_READ:
                            if (row < 5'(hps_pkg::GridRows) && col < 6'(hps_pkg::GridCols))
                            begin
                                solve_next = 1'b0; state_next = S_FETCH;
                            end
                        default: ;
                    endcase
                end
            S_FETCH:
            begin
                cmd.addr = hps_pkg::AddrW'(32'(nr) * hps_pkg::GridCols + 32'(nc));
                if (!ph_reg)
                begin
                    cmd.op = hps_pkg::DP_RD; ph_next = 1'b1;
                end
                else
                begin
                    cmd.op = hps_pkg::DP_LATCH; ph_next = 1'b0;
                    if (k_reg == 3'd4)
                    begin
                        k_next = '0;
                        state_next = solve_reg ? S_MULT : S_CORD;
                        st_next = '0;
                    end
                    else
                        k_next = k_reg + 3'd1;
                end
            end
            S_MULT:
            begin
                cmd.op = hps_pkg::DP_MULT; state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.op = hps_pkg::DP_CALC; state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.op = hps_pkg::DP_UPD;
                state_next = S_FETCH;
                if (c_reg == 6'(hps_pkg::GridCols - 1))
                begin
                    c_next = '0;
                    if (r_reg == 5'(hps_pkg::GridRows - 1))
                    begin
                        r_next = '0;
                        cnt_next = cnt_reg + 16'd1;
                        state_next = S_DONE;
                    end
                    else
                        r_next = r_reg + 5'd1;
                end
                else
                    c_next = c_reg + 6'd1;
            end
            S_CORD:
            begin
                if (st_reg == '0) cmd.op = hps_pkg::DP_CINIT;
                else cmd.op = hps_pkg::DP_CSTEP;
                st_next = st_reg + 5'd1;
                if (st_reg == 5'(hps_pkg::CordicSteps))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // After a sweep the error and the sweep cap decide whether another one runs.
                if (solve_reg && stat.error_sum > 48'(error_threshold)
                    && cnt_reg < max_sweeps)
                begin
                    cmd.op = hps_pkg::DP_CLRERR;
                    state_next = S_FETCH;
                end
                else
                begin
                    conv_next = stat.error_sum <= 48'(error_threshold);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            r_reg <= '0; c_reg <= '0; k_reg <= '0; ph_reg <= 1'b0;
            solve_reg <= 1'b0; cnt_reg <= '0; st_reg <= '0; conv_reg <= 1'b0;
            done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg <= r_next; c_reg <= c_next; k_reg <= k_next; ph_reg <= ph_next;
            solve_reg <= solve_next; cnt_reg <= cnt_next; st_reg <= st_next;
            conv_reg <= conv_next;
            done <= (state_reg == S_DONE) && (state_next == S_IDLE);
        end
    end

    assign busy = (state_reg != S_IDLE) || done;
    assign kind = solve_reg;
    assign sweeps_done = solve_reg ? cnt_reg : '0;
    assign converged = solve_reg && conv_reg;
endmodule
`default_nettype wire

[rtl/core/harmonic_potential_sor_planner_unit.sv]
// Top level of the harmonic potential planner: registers, controller, datapath.
// Load: a new command may follow at once. Read: five neighbor fetches (issue and
// latch each), CORDIC setup and steps, an end state, then the result strobe.
// Solve: for every cell in each sweep, five fetches over the single memory port,
// then neighbor sum, product and update. Reset clears control and registers to
// defaults; the potential memory is not cleared. Results cannot be stalled.
`default_nettype none
module harmonic_potential_sor_planner_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         operation,
    input  wire logic [4:0]         row,
    input  wire logic [5:0]         col,
    input  wire logic signed [17:0] load_value,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    result_valid,
    output logic                    result_kind,
    output logic signed [17:0]      cell_potential,
    output logic                    cell_fixed,
    output logic signed [14:0]      angle,
    output logic [15:0]             sweeps_done,
    output logic                    converged
);
    logic [31:0] thr_reg;
    logic [15:0] max_reg, gain_reg;
    hps_pkg::dp_cmd_t  cmd;
    hps_pkg::dp_stat_t stat;
    logic signed [17:0] center;
    logic signed [14:0] ang;
    logic kind;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 32'd4295; max_reg <= 16'd4096; gain_reg <= 16'd52429;
        end
        else if (cfg_valid)
        begin
            unique case (hps_pkg::reg_idx_t'(cfg_index))
                hps_pkg::REG_THRESH: thr_reg <= cfg_data;
                hps_pkg::REG_SWEEPS: max_reg <= cfg_data[15:0];
                hps_pkg::REG_GAIN:   gain_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    hps_ctrl u_ctrl (
        .clk, .rst_n, .start, .operation, .row, .col,
        .error_threshold(thr_reg), .max_sweeps(max_reg), .stat, .cmd, .busy,
        .done(result_valid), .kind, .sweeps_done, .converged
    );

    hps_datapath u_dp (
        .clk, .cmd, .load_value, .overrelax_gain(gain_reg), .stat, .center,
        .angle(ang)
    );

    assign result_kind = kind;
    assign cell_potential = kind ? '0 : center;
    assign cell_fixed = !kind && stat.center_fixed;
    assign angle = kind ? '0 : ang;
endmodule
`default_nettype wire

[dv/harmonic_potential_sor_planner_unit_test.sv]
// Self-checking testbench for the harmonic potential planner: grid loads, solves and reads.
`default_nettype none
module harmonic_potential_sor_planner_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 200000;
    localparam int DrainCycles = 60;
    localparam int SolveChance = 6;  // per thousand random commands

    typedef struct {
        logic               kind;
        logic signed [17:0] potential;
        logic               fixed;
        logic signed [14:0] angle;
        logic [15:0]        sweeps;
        logic               conv;
    } planner_answer_t;

    class grid_scoreboard;
        int              cell_value[hps_pkg::Cells];
        logic [31:0]     err_limit;
        logic [15:0]     sweep_cap;
        logic [15:0]     gain;
        planner_answer_t pending[$];
        int              errors;

        // atan(2^-i) in 1/64 degree, scaled by 2^16
        longint atan_q[24] = '{188743680, 111421900, 58872272, 29884485, 15000234,
            7507429, 3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

        function new();
            err_limit = 32'd4295;
            sweep_cap = 16'd4096;
            gain = 16'd52429;
            errors = 0;
            foreach (cell_value[k]) cell_value[k] = 0;
        endfunction

        function void set_reg(hps_pkg::reg_idx_t idx, logic [31:0] data);
            case (idx)
                hps_pkg::REG_THRESH: err_limit = data;
                hps_pkg::REG_SWEEPS: sweep_cap = data[15:0];
                hps_pkg::REG_GAIN:   gain = data[15:0];
                default: ;
            endcase
        endfunction

        function int neighbor(int r, int c);
            if (r < 0 || r >= hps_pkg::GridRows || c < 0 || c >= hps_pkg::GridCols)
                return 65536;
            return cell_value[r * hps_pkg::GridCols + c];
        endfunction

        function bit pinned(int v);
            return v == 0 || v == 65536;
        endfunction

        function longint relax_sweep();
            longint err, s, acc, d, nv;
            int old;
            err = 0;
            for (int r = 0; r < hps_pkg::GridRows; r++) begin
                for (int c = 0; c < hps_pkg::GridCols; c++) begin
                    old = cell_value[r * hps_pkg::GridCols + c];
                    if (!pinned(old)) begin
                        s = longint'(neighbor(r - 1, c)) + neighbor(r + 1, c)
                          + neighbor(r, c - 1) + neighbor(r, c + 1);
                        acc = s * 65536 + longint'(gain) * (s - 4 * longint'(old));
                        nv = (acc + 131072) >>> 18;
                        if (nv > 131071) nv = 131071;
                        if (nv < -131072) nv = -131072;
                        d = nv - old;
                        err += d * d;
                        if (err > 64'hFFFF_FFFF_FFFF) err = 64'hFFFF_FFFF_FFFF;
                        cell_value[r * hps_pkg::GridCols + c] = int'(nv);
                    end
                end
            end
            return err;
        endfunction

        function int gradient_angle(int r, int c);
            longint y, x, z, xs, ys, res;
            y = (longint'(neighbor(r - 1, c)) - neighbor(r + 1, c)) * 256;
            x = (longint'(neighbor(r, c - 1)) - neighbor(r, c + 1)) * 256;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                z = (y >= 0) ? 4 * atan_q[0] : -4 * atan_q[0];
                x = -x;
                y = -y;
            end
            for (int i = 0; i < hps_pkg::CordicSteps; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; z += atan_q[i];
                end else begin
                    x -= ys; y += xs; z -= atan_q[i];
                end
            end
            res = -((z + 32768) >>> 16);
            if (res > 11520) res = 11520;
            if (res < -11520) res = -11520;
            return int'(res);
        endfunction

        function void note(hps_pkg::op_t op, logic [4:0] r, logic [5:0] c,
                           logic signed [17:0] v);
            planner_answer_t a;
            longint err;
            int cnt;
            bit in_grid;
            in_grid = r < hps_pkg::GridRows && c < hps_pkg::GridCols;
            a = '{1'b0, 18'sd0, 1'b0, 15'sd0, 16'd0, 1'b0};
            case (op)
                hps_pkg::OP_LOAD:
                    if (in_grid) cell_value[r * hps_pkg::GridCols + c] = int'(v);
                hps_pkg::OP_SOLVE: begin
                    cnt = 0;
                    do begin
                        err = relax_sweep();
                        cnt = (cnt + 1) & 16'hFFFF;
                    end while (err > longint'(err_limit) && cnt < sweep_cap);
                    a.kind = 1'b1;
                    a.sweeps = cnt[15:0];
                    a.conv = err <= longint'(err_limit);
                    pending.push_back(a);
                end
                hps_pkg::OP_READ: if (in_grid) begin
                    a.potential = 18'(cell_value[r * hps_pkg::GridCols + c]);
                    a.fixed = pinned(cell_value[r * hps_pkg::GridCols + c]);
                    if (!a.fixed) a.angle = 15'(gradient_angle(r, c));
                    pending.push_back(a);
                end
                default: ;
            endcase
        endfunction

        function void check(planner_answer_t got);
            planner_answer_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word, kind %0d", got.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.kind) begin
                $error("result_kind: expected %0d, actual %0d", e.kind, got.kind);
                errors++;
            end
            if (got.potential !== e.potential) begin
                $error("cell_potential: expected %0d, actual %0d", e.potential, got.potential);
                errors++;
            end
            if (got.fixed !== e.fixed) begin
                $error("cell_fixed: expected %0d, actual %0d", e.fixed, got.fixed);
                errors++;
            end
            if (got.angle !== e.angle) begin
                $error("angle: expected %0d, actual %0d", e.angle, got.angle);
                errors++;
            end
            if (got.sweeps !== e.sweeps) begin
                $error("sweeps_done: expected %0d, actual %0d", e.sweeps, got.sweeps);
                errors++;
            end
            if (got.conv !== e.conv) begin
                $error("converged: expected %0d, actual %0d", e.conv, got.conv);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         operation = hps_pkg::OP_NONE;
    logic [4:0]         row = '0;
    logic [5:0]         col = '0;
    logic signed [17:0] load_value = '0;
    logic               cfg_valid = 1'b0;
    logic [1:0]         cfg_index = hps_pkg::REG_NONE;
    logic [31:0]        cfg_data = '0;
    logic               busy, cfg_ready, result_valid, result_kind, cell_fixed, converged;
    logic signed [17:0] cell_potential;
    logic signed [14:0] angle;
    logic [15:0]        sweeps_done;

    grid_scoreboard sb = new();
    int idle_pct = 0;
    int quiet_cycles = 0;

    harmonic_potential_sor_planner_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .row(row), .col(col), .load_value(load_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result_kind(result_kind),
        .cell_potential(cell_potential), .cell_fixed(cell_fixed), .angle(angle),
        .sweeps_done(sweeps_done), .converged(converged)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && result_valid)
            sb.check('{result_kind, cell_potential, cell_fixed, angle, sweeps_done, converged});
    end

    // A solve can be silent for a long time, so only a long stretch with no word
    // moving in any direction counts as a hang.
    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic issue(hps_pkg::op_t op, logic [4:0] r, logic [5:0] c,
                         logic signed [17:0] v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        row <= r;
        col <= c;
        load_value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note(op, r, c, v);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(hps_pkg::reg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    function automatic logic signed [17:0] pick_value();
        case ($urandom_range(6))
            0: return 18'sd0;
            1: return hps_pkg::OneQ16;
            2: return 18'($urandom);
            3: return 18'sd65536 + $signed(18'($urandom_range(64))) - 18'sd32;
            4: return 18'($urandom_range(131071, 131000));
            5: return -18'sd131072 + $signed(18'($urandom_range(50)));
            default: return 18'($urandom_range(65536));
        endcase
    endfunction

    task automatic random_phase(int count, int idle);
        int pick;
        logic [4:0] r;
        logic [5:0] c;
        idle_pct = idle;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(999);
            // Mostly in-grid addresses; a few run past the edge.
            r = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 28)) : 5'($urandom_range(27));
            c = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 36)) : 6'($urandom_range(35));
            if (pick < SolveChance)
                issue(hps_pkg::OP_SOLVE, r, c, 18'($urandom));
            else if (pick < 16)
                issue(hps_pkg::OP_NONE, r, c, 18'($urandom));
            else if (pick < 560)
                issue(hps_pkg::OP_LOAD, r, c, pick_value());
            else
                issue(hps_pkg::OP_READ, r, c, 18'($urandom));
        end
        settle();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every cell gets a pinned value first, so no read ever sees an unwritten cell.
        for (int k = 0; k < hps_pkg::Cells; k++)
            issue(hps_pkg::OP_LOAD, 5'(k / hps_pkg::GridCols), 6'(k % hps_pkg::GridCols),
                  $urandom_range(1) ? hps_pkg::OneQ16 : 18'sd0);
        settle();

        // All cells pinned: the widest sweep cap and a zero threshold stop after one sweep.
        write_reg(hps_pkg::REG_SWEEPS, 32'd65535);
        write_reg(hps_pkg::REG_THRESH, 32'd0);
        issue(hps_pkg::OP_SOLVE, 5'd0, 6'd0, 18'sd0);
        settle();

        write_reg(hps_pkg::REG_SWEEPS, 32'd1);
        issue(hps_pkg::OP_LOAD, 5'd0, 6'd0, 18'sd131071);
        issue(hps_pkg::OP_LOAD, 5'd27, 6'd35, -18'sd131072);
        issue(hps_pkg::OP_LOAD, 5'd27, 6'd0, 18'sd1);
        issue(hps_pkg::OP_LOAD, 5'd0, 6'd35, 18'sd65535);
        issue(hps_pkg::OP_LOAD, 5'd14, 6'd20, 18'sd65537);
        issue(hps_pkg::OP_LOAD, 5'd10, 6'd10, 18'sd30000);
        issue(hps_pkg::OP_LOAD, 5'd9, 6'd10, 18'sd0);
        issue(hps_pkg::OP_LOAD, 5'd11, 6'd10, 18'sd0);
        issue(hps_pkg::OP_LOAD, 5'd10, 6'd9, 18'sd0);
        issue(hps_pkg::OP_LOAD, 5'd10, 6'd11, 18'sd0);
        issue(hps_pkg::OP_LOAD, 5'd31, 6'd63, 18'sd5);
        issue(hps_pkg::OP_READ, 5'd0, 6'd0, 18'sd0);
        issue(hps_pkg::OP_READ, 5'd27, 6'd35, 18'sd0);
        issue(hps_pkg::OP_READ, 5'd27, 6'd0, 18'sd0);
        issue(hps_pkg::OP_READ, 5'd0, 6'd35, 18'sd0);
        issue(hps_pkg::OP_READ, 5'd14, 6'd20, 18'sd0);
        issue(hps_pkg::OP_READ, 5'd10, 6'd10, 18'sd0);   // free cell with a flat neighborhood
        issue(hps_pkg::OP_READ, 5'd9, 6'd10, 18'sd0);
        issue(hps_pkg::OP_READ, 5'd28, 6'd3, 18'sd0);
        issue(hps_pkg::OP_READ, 5'd3, 6'd36, 18'sd0);
        issue(hps_pkg::OP_NONE, 5'd3, 6'd3, -18'sd1);
        issue(hps_pkg::OP_SOLVE, 5'd0, 6'd0, 18'sd0);
        issue(hps_pkg::OP_READ, 5'd10, 6'd10, 18'sd0);
        settle();

        write_reg(hps_pkg::REG_THRESH, $urandom);
        write_reg(hps_pkg::REG_SWEEPS, $urandom_range(3, 1));
        write_reg(hps_pkg::REG_GAIN, $urandom);
        random_phase(250, 33);

        write_reg(hps_pkg::REG_THRESH, 32'd0);
        write_reg(hps_pkg::REG_SWEEPS, 32'd2);
        write_reg(hps_pkg::REG_GAIN, 32'd0);
        random_phase(250, 68);

        write_reg(hps_pkg::REG_THRESH, 32'hFFFF_FFFF);
        write_reg(hps_pkg::REG_SWEEPS, 32'd3);
        write_reg(hps_pkg::REG_GAIN, 32'd65535);
        random_phase(250, 0);

        if (sb.pending.size() != 0) begin
            $error("%0d expected result words never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
